[hw/rtl/sensor_command_line_parser_core_macros.svh]
// Assertion macros for the sensor command line parser core.
`ifndef SENSOR_COMMAND_LINE_PARSER_CORE_MACROS_SVH
`define SENSOR_COMMAND_LINE_PARSER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SCLP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sclp assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define SCLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sclp assertion failed: next-cycle implication");

`endif

[hw/rtl/sclp_pkg.sv]
// Package: item types, command table and codes for the command line parser.
`timescale 1ns / 1ps

package sclp_pkg;

    // Line and matcher sizing
    localparam int LINE_MAX   = 255;
    localparam int POS_W      = $clog2(LINE_MAX + 1);
    localparam int NUM_CMDS   = 7;
    localparam int NUM_OFFSET = 7;
    localparam int CMD_CHARS  = 8;
    localparam int CHAR_IDX_W = $clog2(CMD_CHARS);

    // Command codes on the result item
    localparam logic [3:0] CMD_NONE    = 4'd0;
    localparam logic [3:0] CMD_SCALE_F = 4'd1;
    localparam logic [3:0] CMD_SCALE_C = 4'd2;
    localparam logic [3:0] CMD_STOP    = 4'd3;
    localparam logic [3:0] CMD_START   = 4'd4;
    localparam logic [3:0] CMD_PERIOD  = 4'd5;
    localparam logic [3:0] CMD_LOG     = 4'd6;
    localparam logic [3:0] CMD_OFF     = 4'd7;
    localparam logic [3:0] CMD_INVALID = 4'd8;

    // Configuration register indexes
    localparam logic CFG_LOG_ENABLED  = 1'b0;
    localparam logic CFG_START_PERIOD = 1'b1;

    // Item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Number scan phases after the PERIOD= prefix
    localparam logic [1:0] NUM_WAIT   = 2'd0;
    localparam logic [1:0] NUM_DIGITS = 2'd1;
    localparam logic [1:0] NUM_DONE   = 2'd2;

    // Special bytes
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_VT   = 8'h0B;
    localparam logic [7:0] CH_FF   = 8'h0C;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_MIN  = 8'h2D;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;

    // Command table, zero padded
    localparam logic [7:0] CMD_TEXT [NUM_CMDS][CMD_CHARS] = '{
        '{"S", "C", "A", "L", "E", "=", "F", 8'h00},
        '{"S", "C", "A", "L", "E", "=", "C", 8'h00},
        '{"S", "T", "O", "P", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"S", "T", "A", "R", "T", 8'h00, 8'h00, 8'h00},
        '{"P", "E", "R", "I", "O", "D", "=", 8'h00},
        '{"L", "O", "G", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"O", "F", "F", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [POS_W-1:0] CMD_LEN [NUM_CMDS] = '{
        POS_W'(7), POS_W'(7), POS_W'(4), POS_W'(5), POS_W'(7), POS_W'(3), POS_W'(3)
    };
    localparam logic [NUM_CMDS-1:0] CMD_PREFIX = 7'b0110000;
    localparam logic [3:0] CMD_CODE [NUM_CMDS] = '{
        CMD_SCALE_F, CMD_SCALE_C, CMD_STOP, CMD_START, CMD_PERIOD, CMD_LOG, CMD_OFF
    };

    typedef struct packed {
        logic       kind;
        logic [7:0] char_in;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  command_code;
        logic        report_due;
        logic        no_log_notice;
        logic        celsius_mode;
        logic        running;
        logic [15:0] period_now;
        logic        halted;
    } t_out_item;

endpackage

[hw/rtl/sensor_command_line_parser_core.sv]
// Sensor command line parser: byte matcher, period scan, tick counter, status.
// An accepted item is held in the input register; its decoded result goes to the result register.
// Throughput: one item per cycle while the result is not stalled; the decode between the two registers sets it.
// While a result waits, one more item is taken into the input register.
// Reset (i_rst_n low, synchronous) clears the line, sets Fahrenheit, running,
// period 1, elapsed count saturated, log disabled, not halted; no clearing pass.
`timescale 1ns / 1ps

`include "sensor_command_line_parser_core_macros.svh"

module sensor_command_line_parser_core
    import sclp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_wr_data
);

    // Input stage
    logic               r_in_valid;
    t_in_item           r_in_item;
    // Result stage
    logic               r_out_valid;
    t_out_item          r_out_item;
    // Line matcher state
    logic [POS_W-1:0]    r_pos,     n_pos;
    logic [NUM_CMDS-1:0] r_mask,    n_mask;
    logic [1:0]          r_phase,   n_phase;
    logic                r_neg,     n_neg;
    logic [15:0]         r_num,     n_num;
    logic                r_closed,  n_closed;
    // Status state
    logic                r_celsius, n_celsius;
    logic                r_run,     n_run;
    logic [15:0]         r_period,  n_period;
    logic [15:0]         r_elapsed, n_elapsed;
    logic                r_halt,    n_halt;
    logic                r_log_en;

    t_out_item           n_result;
    logic                move;

    assign move        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || move;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Decode one item against the current state
    always_comb begin
        logic [7:0]  c;
        logic        blank;
        logic        digit;
        logic        take_num;
        logic [19:0] prod;
        logic [3:0]  code;
        logic        found;
        logic        hit;

        n_pos     = r_pos;
        n_mask    = r_mask;
        n_phase   = r_phase;
        n_neg     = r_neg;
        n_num     = r_num;
        n_closed  = r_closed;
        n_celsius = r_celsius;
        n_run     = r_run;
        n_period  = r_period;
        n_elapsed = r_elapsed;
        n_halt    = r_halt;
        n_result  = '0;

        c        = r_in_item.char_in;
        blank    = (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) ||
                   (c == CH_VT) || (c == CH_FF);
        digit    = (c >= CH_0) && (c <= CH_9);
        prod     = ({4'd0, r_num} << 3) + ({4'd0, r_num} << 1) + {16'd0, c[3:0]};
        code     = CMD_INVALID;
        found    = 1'b0;
        hit      = 1'b0;
        take_num = 1'b0;

        if (!r_halt) begin
            if (r_in_item.kind == KIND_TICK) begin
                // Count seconds, saturating, and fire a report when due
                if (r_elapsed != 16'hFFFF) begin
                    n_elapsed = r_elapsed + 16'd1;
                end
                if (r_run && (n_elapsed >= r_period)) begin
                    n_result.report_due = 1'b1;
                    n_elapsed = '0;
                end
            end else if (c == CH_NL) begin
                // Pick the first surviving command whose length fits
                for (int i = 0; i < NUM_CMDS; i++) begin
                    hit = CMD_PREFIX[i] ? (r_pos >= CMD_LEN[i]) : (r_pos == CMD_LEN[i]);
                    if (!found && r_mask[i] && hit) begin
                        found = 1'b1;
                        code  = CMD_CODE[i];
                    end
                end
                n_result.command_code = code;
                case (code)
                    CMD_SCALE_F: n_celsius = 1'b0;
                    CMD_SCALE_C: n_celsius = 1'b1;
                    CMD_STOP:    n_run = 1'b0;
                    CMD_START:   n_run = 1'b1;
                    CMD_PERIOD:  n_period = r_neg ? 16'd0 : r_num;
                    CMD_LOG:     n_result.no_log_notice = !r_log_en;
                    CMD_OFF:     n_halt = 1'b1;
                    default:     ;
                endcase
                // Clear the line
                n_pos    = '0;
                n_mask   = '1;
                n_phase  = NUM_WAIT;
                n_neg    = 1'b0;
                n_num    = '0;
                n_closed = 1'b0;
            end else if (!r_closed && (r_pos < POS_W'(LINE_MAX))) begin
                if (c == CH_NUL) begin
                    n_closed = 1'b1;
                end else begin
                    // Drop candidates that mismatch or run past their length
                    for (int i = 0; i < NUM_CMDS; i++) begin
                        if (r_pos < CMD_LEN[i]) begin
                            if (CMD_TEXT[i][r_pos[CHAR_IDX_W-1:0]] != c) begin
                                n_mask[i] = 1'b0;
                            end
                        end else if (!CMD_PREFIX[i]) begin
                            n_mask[i] = 1'b0;
                        end
                    end
                    // Scan the period number after the prefix
                    if (r_pos >= POS_W'(NUM_OFFSET)) begin
                        if (r_phase == NUM_WAIT) begin
                            if (c == CH_PLUS || c == CH_MIN) begin
                                n_neg   = (c == CH_MIN);
                                n_phase = NUM_DIGITS;
                            end else if (!blank) begin
                                n_phase  = NUM_DIGITS;
                                take_num = 1'b1;
                            end
                        end else if (r_phase == NUM_DIGITS) begin
                            take_num = 1'b1;
                        end
                        if (take_num) begin
                            if (digit) begin
                                n_num = (prod[19:16] != 4'd0) ? 16'hFFFF : prod[15:0];
                            end else begin
                                n_phase = NUM_DONE;
                            end
                        end
                    end
                    n_pos = r_pos + POS_W'(1);
                end
            end
        end

        n_result.celsius_mode = n_celsius;
        n_result.running      = n_run;
        n_result.period_now   = n_period;
        n_result.halted       = n_halt;
    end

    // Advance handshake, state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_mask      <= '1;
            r_phase     <= NUM_WAIT;
            r_neg       <= 1'b0;
            r_num       <= '0;
            r_closed    <= 1'b0;
            r_celsius   <= 1'b0;
            r_run       <= 1'b1;
            r_period    <= 16'd1;
            r_elapsed   <= 16'hFFFF;
            r_halt      <= 1'b0;
            r_log_en    <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (move) begin
                r_out_valid <= 1'b1;
                r_pos       <= n_pos;
                r_mask      <= n_mask;
                r_phase     <= n_phase;
                r_neg       <= n_neg;
                r_num       <= n_num;
                r_closed    <= n_closed;
                r_celsius   <= n_celsius;
                r_run       <= n_run;
                r_period    <= n_period;
                r_elapsed   <= n_elapsed;
                r_halt      <= n_halt;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_LOG_ENABLED:  r_log_en <= i_cfg_wr_data[0];
                    CFG_START_PERIOD: r_period <= i_cfg_wr_data;
                    default:          ;
                endcase
            end
        end
    end

    // Hold payload registers without reset
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (move) begin
            r_out_item <= n_result;
        end
    end

    // Checks
    `SCLP_ASSERT_NEXT(a_halt_sticky, i_clk, i_rst_n, r_halt && !i_cfg_wr_en, r_halt)
    `SCLP_ASSERT_IMPLY(a_report_no_cmd, i_clk, i_rst_n,
        r_out_valid && r_out_item.report_due, r_out_item.command_code == CMD_NONE)
    `SCLP_ASSERT_IMPLY(a_notice_on_log, i_clk, i_rst_n,
        r_out_valid && r_out_item.no_log_notice, r_out_item.command_code == CMD_LOG)
    `SCLP_ASSERT_IMPLY(a_stall_blocks_in, i_clk, i_rst_n,
        r_in_valid && r_out_valid && !i_out_ready, !o_in_ready)

endmodule
